// ----- rtl/core/bht_pkg.sv -----
// Shared widths, operation codes and status codes of the bucketized hash table.
package bht_pkg;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned VAL_W    = 64;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned MASK_RESET = 255;

    localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_CMP   = 5'b01000,
        S_ACT   = 5'b10000
    } t_state;

endpackage

// ----- rtl/core/bucketized_hash_table.sv -----
// Top level of the bucketized hash table: sequencer, valid rows, slot compare.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_bucket_mask
//  in      | in        | i_in_valid  / o_in_ready  | i_mode, i_lookup_key, i_put_value
//  out     | out       | o_out_valid / i_out_ready | o_status, o_read_value
//
//  An operation reads and compares k slots of its bucket in turn, k = slots scanned (1..SLOTS),
//  with one 64-bit key comparator reused per slot behind the slot memory's one read port.
//  After reset a clearing pass zeroes the valid rows, one bucket a cycle.
//  Input is not taken during the clearing pass nor while an operation is in flight.
//  A finished result waits in the output register; the action stalls only while it is full.
module bucketized_hash_table #(
    parameter int unsigned BUCKETS = 256,
    parameter int unsigned SLOTS   = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bht_pkg::MASK_W-1:0]   i_cfg_bucket_mask,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bht_pkg::MODE_W-1:0]   i_mode,
    input  logic [bht_pkg::KEY_W-1:0]    i_lookup_key,
    input  logic [bht_pkg::VAL_W-1:0]    i_put_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bht_pkg::STATUS_W-1:0] o_status,
    output logic [bht_pkg::VAL_W-1:0]    o_read_value
);

    localparam int unsigned DEPTH  = BUCKETS * SLOTS;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned NMASK  = 1 << bht_pkg::MASK_W;

    bht_pkg::t_state r_state, n_state;

    logic [bht_pkg::MASK_W-1:0]   r_mask;
    logic [bht_pkg::MODE_W-1:0]   r_mode;
    logic [bht_pkg::KEY_W-1:0]    r_key;
    logic [bht_pkg::VAL_W-1:0]    r_val;
    logic [BIDX_W-1:0]            r_bkt;
    logic [SW-1:0]                r_slot;
    logic                         r_hit;
    logic [SLOTS-1:0]             r_vrow;
    logic [SLOTS-1:0]             r_vmem [BUCKETS];
    logic                         r_out_valid;
    logic [bht_pkg::STATUS_W-1:0] r_status;
    logic [bht_pkg::VAL_W-1:0]    r_rdval;

    logic [BIDX_W-1:0]            w_mod_tab [NMASK];
    logic [bht_pkg::MASK_W-1:0]   w_masked;
    logic [bht_pkg::KEY_W-1:0]    w_rd_key;
    logic [bht_pkg::VAL_W-1:0]    w_rd_value;
    logic [AW-1:0]                w_base;
    logic [AW-1:0]                w_rd_addr;
    logic [AW-1:0]                w_wr_addr;
    logic                         w_match;
    logic                         w_last;
    logic [SW-1:0]                w_free;
    logic                         w_has_free;
    logic                         w_act;
    logic                         w_kwe;
    logic                         w_vwe;
    logic [SLOTS-1:0]             w_vrow_new;
    logic [bht_pkg::STATUS_W-1:0] w_status;
    logic [bht_pkg::VAL_W-1:0]    w_rdval;

    // bucket index of every masked key byte, modulo the bucket count
    for (genvar g = 0; g < NMASK; g++) begin : g_mod
        localparam int unsigned MODV = g % BUCKETS;
        assign w_mod_tab[g] = BIDX_W'(MODV);
    end

    assign w_masked  = i_lookup_key[bht_pkg::MASK_W-1:0] & r_mask;
    assign w_base    = AW'(r_bkt) * AW'(SLOTS);
    assign w_rd_addr = w_base + AW'(r_slot);
    assign w_wr_addr = w_base + AW'(w_free);
    assign w_match   = r_vrow[r_slot] && (w_rd_key == r_key);
    assign w_last    = (r_slot == SW'(SLOTS - 1));
    assign w_act     = (r_state == bht_pkg::S_ACT) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_free     = '0;
        w_has_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_vrow[i]) begin
                w_free     = SW'(i);
                w_has_free = 1'b1;
            end
        end
    end

    always_comb begin
        w_kwe      = 1'b0;
        w_vwe      = 1'b0;
        w_vrow_new = r_vrow;
        w_status   = bht_pkg::ST_NOT_FOUND;
        w_rdval    = '0;
        case (r_mode)
            bht_pkg::MODE_GET: begin
                if (r_hit) begin
                    w_status = bht_pkg::ST_FOUND;
                    w_rdval  = w_rd_value;
                end
            end
            bht_pkg::MODE_PUT: begin
                if (r_hit) begin
                    w_status = bht_pkg::ST_PRESENT;
                end else if (w_has_free) begin
                    w_status           = bht_pkg::ST_INSERTED;
                    w_kwe              = 1'b1;
                    w_vwe              = 1'b1;
                    w_vrow_new[w_free] = 1'b1;
                end else begin
                    w_status = bht_pkg::ST_FULL;
                end
            end
            bht_pkg::MODE_REMOVE: begin
                if (r_hit) begin
                    w_status           = bht_pkg::ST_FOUND;
                    w_rdval            = w_rd_value;
                    w_vwe              = 1'b1;
                    w_vrow_new[r_slot] = 1'b0;
                end
            end
            default: begin
                w_status = bht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bht_pkg::S_CLEAR: if (r_bkt == BIDX_W'(BUCKETS - 1)) n_state = bht_pkg::S_IDLE;
            bht_pkg::S_IDLE:  if (i_in_valid) n_state = bht_pkg::S_RD;
            bht_pkg::S_RD:    n_state = bht_pkg::S_CMP;
            bht_pkg::S_CMP:   n_state = (w_match || w_last) ? bht_pkg::S_ACT : bht_pkg::S_RD;
            bht_pkg::S_ACT:   if (w_act) n_state = bht_pkg::S_IDLE;
            default:          n_state = bht_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bht_pkg::S_CLEAR;
            r_mask      <= bht_pkg::MASK_W'(bht_pkg::MASK_RESET);
            r_bkt       <= '0;
            r_slot      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_mask <= i_cfg_bucket_mask;
            end
            case (r_state)
                bht_pkg::S_CLEAR: begin
                    r_bkt <= r_bkt + BIDX_W'(1);
                end
                bht_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_bkt  <= w_mod_tab[w_masked];
                        r_slot <= '0;
                        r_hit  <= 1'b0;
                    end
                end
                bht_pkg::S_CMP: begin
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end else if (!w_last) begin
                        r_slot <= r_slot + SW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (w_act) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bht_pkg::S_IDLE) && i_in_valid) begin
            r_mode <= i_mode;
            r_key  <= i_lookup_key;
            r_val  <= i_put_value;
        end
        if (w_act) begin
            r_status <= w_status;
            r_rdval  <= w_rdval;
        end
    end

    // valid rows, one word of SLOTS bits per bucket
    always_ff @(posedge i_clk) begin
        if (r_state == bht_pkg::S_CLEAR) begin
            r_vmem[r_bkt] <= '0;
        end else if (w_act && w_vwe) begin
            r_vmem[r_bkt] <= w_vrow_new;
        end
        if (r_state == bht_pkg::S_RD) begin
            r_vrow <= r_vmem[r_bkt];
        end
    end

    bht_slot_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_act && w_kwe),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (r_key),
        .i_wr_value (r_val),
        .i_rd_en    (r_state == bht_pkg::S_RD),
        .i_rd_addr  (w_rd_addr),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == bht_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rdval;

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == bht_pkg::S_RD))
        else $error("transfer did not start a bucket read");

    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bht_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    a_result_from_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == bht_pkg::S_ACT))
        else $error("result appeared without an action step");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bht_pkg::S_CMP) |-> (r_slot <= SW'(SLOTS - 1)))
        else $error("slot index beyond bucket");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= bht_pkg::ST_FULL))
        else $error("illegal status code");

endmodule

// ----- rtl/core/bht_slot_mem.sv -----
// Key and value storage of all slots: one write port, one registered read port.
module bht_slot_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [bht_pkg::KEY_W-1:0] i_wr_key,
    input  logic [bht_pkg::VAL_W-1:0] i_wr_value,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [bht_pkg::KEY_W-1:0] o_rd_key,
    output logic [bht_pkg::VAL_W-1:0] o_rd_value
);

    logic [bht_pkg::KEY_W-1:0] r_key_mem [DEPTH];
    logic [bht_pkg::VAL_W-1:0] r_val_mem [DEPTH];
    logic [bht_pkg::KEY_W-1:0] r_rd_key;
    logic [bht_pkg::VAL_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_rd_key   <= r_key_mem[i_rd_addr];
            r_rd_value <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule

// ----- tb/tb_bucketized_hash_table.sv -----
// Self-checking testbench for the bucketized hash table: get, put, remove and undefined-mode traffic.
module tb_bucketized_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUCKETS     = 256;
    localparam int unsigned SLOTS       = 4;
    localparam int unsigned TABLE_SLOTS = BUCKETS * SLOTS;
    localparam int unsigned KEY_POOL    = 24;
    localparam int unsigned HOT_BUCKETS = 6;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 2 * SLOTS + 2;

    localparam logic [bht_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;

    typedef struct packed {
        logic [bht_pkg::STATUS_W-1:0] status;
        logic [bht_pkg::VAL_W-1:0]    value;
    } t_op_result;

    logic                         i_clk             = 1'b0;
    logic                         i_rst_n           = 1'b0;
    logic                         i_cfg_valid       = 1'b0;
    logic                         o_cfg_ready;
    logic [bht_pkg::MASK_W-1:0]   i_cfg_bucket_mask = '0;
    logic                         i_in_valid        = 1'b0;
    logic                         o_in_ready;
    logic [bht_pkg::MODE_W-1:0]   i_mode            = bht_pkg::MODE_GET;
    logic [bht_pkg::KEY_W-1:0]    i_lookup_key      = '0;
    logic [bht_pkg::VAL_W-1:0]    i_put_value       = '0;
    logic                         o_out_valid;
    logic                         i_out_ready       = 1'b0;
    logic [bht_pkg::STATUS_W-1:0] o_status;
    logic [bht_pkg::VAL_W-1:0]    o_read_value;

    logic                       table_valid [TABLE_SLOTS];
    logic [bht_pkg::KEY_W-1:0]  table_key   [TABLE_SLOTS];
    logic [bht_pkg::VAL_W-1:0]  table_value [TABLE_SLOTS];
    logic [bht_pkg::MASK_W-1:0] mask_model;

    t_op_result                pending_results[$];
    t_op_result                want;
    logic [bht_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    int errors        = 0;
    int ops_done      = 0;
    int masks_written = 0;
    int status_count [5];
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int holds_asked   = 0;
    int holds_granted = 0;
    int hold_left     = 0;

    bucketized_hash_table #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bucket_mask (i_cfg_bucket_mask),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_lookup_key      (i_lookup_key),
        .i_put_value       (i_put_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_read_value      (o_read_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_op_result lookup_and_update(input logic [bht_pkg::MODE_W-1:0] mode,
                                                     input logic [bht_pkg::KEY_W-1:0] key,
                                                     input logic [bht_pkg::VAL_W-1:0] val);
        int unsigned base;
        int          hit;
        t_op_result  res;
        base = ((key[bht_pkg::MASK_W-1:0] & mask_model) % BUCKETS) * SLOTS;
        hit  = -1;
        res  = '{status: bht_pkg::ST_NOT_FOUND, value: '0};
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (table_valid[base + s] && table_key[base + s] == key) begin
                hit = base + s;
            end
        end
        case (mode)
            bht_pkg::MODE_GET: begin
                if (hit >= 0) begin
                    res = '{status: bht_pkg::ST_FOUND, value: table_value[hit]};
                end
            end
            bht_pkg::MODE_PUT: begin
                if (hit >= 0) begin
                    res.status = bht_pkg::ST_PRESENT;
                end else begin
                    res.status = bht_pkg::ST_FULL;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (res.status == bht_pkg::ST_FULL && !table_valid[base + s]) begin
                            table_valid[base + s] = 1'b1;
                            table_key[base + s]   = key;
                            table_value[base + s] = val;
                            res.status            = bht_pkg::ST_INSERTED;
                        end
                    end
                end
            end
            bht_pkg::MODE_REMOVE: begin
                if (hit >= 0) begin
                    res              = '{status: bht_pkg::ST_FOUND, value: table_value[hit]};
                    table_valid[hit] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mask_model = bht_pkg::MASK_W'(bht_pkg::MASK_RESET);
            foreach (table_valid[i]) table_valid[i] = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual status=%0d value=%h", $time,
                             o_status, o_read_value);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_status);
                    end
                    if (o_read_value !== want.value) begin
                        errors++;
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.value, o_read_value);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                mask_model = i_cfg_bucket_mask;
            end
            if (i_in_valid && o_in_ready) begin
                want = lookup_and_update(i_mode, i_lookup_key, i_put_value);
                status_count[want.status]++;
                pending_results.push_back(want);
                ops_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            i_out_ready   <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_granted <= holds_asked;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic send_op(input logic [bht_pkg::MODE_W-1:0] mode,
                           input logic [bht_pkg::KEY_W-1:0]  key,
                           input logic [bht_pkg::VAL_W-1:0]  val);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_lookup_key <= key;
        i_put_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [bht_pkg::MASK_W-1:0] mask);
        drain();
        i_cfg_valid       <= 1'b1;
        i_cfg_bucket_mask <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        masks_written++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic fill_key_pool();
        logic [7:0] hot [HOT_BUCKETS];
        foreach (hot[i]) hot[i] = 8'($urandom());
        foreach (key_pool[i]) begin
            key_pool[i]      = rand64();
            key_pool[i][7:0] = hot[$urandom_range(HOT_BUCKETS - 1)];
        end
    endtask

    task automatic run_random_ops(input int count);
        int                         roll;
        logic [bht_pkg::MODE_W-1:0] mode;
        logic [bht_pkg::KEY_W-1:0]  key;
        logic [bht_pkg::VAL_W-1:0]  val;
        fill_key_pool();
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 35) mode = bht_pkg::MODE_GET;
            else if (roll < 70) mode = bht_pkg::MODE_PUT;
            else if (roll < 95) mode = bht_pkg::MODE_REMOVE;
            else mode = MODE_UNDEF;
            key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(KEY_POOL - 1)] : rand64();
            roll = $urandom_range(19);
            val  = (roll == 0) ? '0 : (roll == 1) ? '1 : rand64();
            send_op(mode, key, val);
        end
    endtask

    task automatic test_directed();
        send_op(bht_pkg::MODE_GET, 64'h0, 64'h0);
        send_op(bht_pkg::MODE_REMOVE, 64'h0, 64'h0);
        send_op(MODE_UNDEF, 64'h0, '1);
        send_op(bht_pkg::MODE_PUT, 64'h0, '1);
        send_op(bht_pkg::MODE_PUT, 64'h0, 64'h1234);
        send_op(bht_pkg::MODE_GET, 64'h0, 64'h0);
        send_op(bht_pkg::MODE_PUT, 64'h5, 64'hA5A5_0000_0000_0001);
        send_op(bht_pkg::MODE_PUT, 64'h105, 64'hA5A5_0000_0000_0002);
        send_op(bht_pkg::MODE_PUT, 64'h205, 64'hA5A5_0000_0000_0003);
        send_op(bht_pkg::MODE_PUT, 64'hFFFF_FFFF_FFFF_FF05, 64'h8000_0000_0000_0000);
        send_op(bht_pkg::MODE_PUT, 64'h305, 64'hDEAD);
        send_op(bht_pkg::MODE_GET, 64'hFFFF_FFFF_FFFF_FF05, 64'h0);
        send_op(bht_pkg::MODE_REMOVE, 64'h105, 64'h0);
        send_op(bht_pkg::MODE_PUT, 64'h405, 64'hBEEF);
        send_op(bht_pkg::MODE_GET, 64'h405, 64'h0);
        send_op(bht_pkg::MODE_GET, 64'h105, 64'h0);
        send_op(MODE_UNDEF, 64'h5, 64'h0);
        send_op(bht_pkg::MODE_GET, 64'h5, 64'h0);
        send_op(bht_pkg::MODE_PUT, '1, 64'h0);
        send_op(bht_pkg::MODE_GET, '1, 64'h0);
        send_op(bht_pkg::MODE_REMOVE, 64'h0, 64'h0);
        send_op(bht_pkg::MODE_GET, 64'h0, 64'h0);
        drain();
    endtask

    task automatic test_idle_phases();
        int idle_sets [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{16, 16}};
        foreach (idle_sets[p]) begin
            in_idle_pct   = idle_sets[p][0];
            out_stall_pct = idle_sets[p][1];
            run_random_ops(180);
        end
        drain();
    endtask

    task automatic test_bucket_masks();
        logic [bht_pkg::MASK_W-1:0] masks [5] = '{8'h00, 8'h03, 8'hA5, 8'h80, 8'hFF};
        foreach (masks[m]) begin
            write_mask(masks[m]);
            in_idle_pct   = (m % 2 == 0) ? 16 : 0;
            out_stall_pct = (m % 3 == 0) ? 65 : 16;
            run_random_ops(150);
        end
        drain();
    endtask

    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        holds_asked++;
        run_random_ops(60);
        drain();
    endtask

    initial begin
        foreach (status_count[i]) status_count[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_idle_phases();
        test_bucket_masks();
        test_backpressure();
        $display("Ran %0d operations across %0d mask writes, with idle phases and a long stall",
                 ops_done, masks_written);
        $display("Outcomes: %0d misses, %0d found, %0d inserted, %0d present, %0d full",
                 status_count[bht_pkg::ST_NOT_FOUND],
                 status_count[bht_pkg::ST_FOUND],
                 status_count[bht_pkg::ST_INSERTED],
                 status_count[bht_pkg::ST_PRESENT],
                 status_count[bht_pkg::ST_FULL]);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bht_pkg.sv
rtl/core/bht_slot_mem.sv
rtl/core/bucketized_hash_table.sv
tb/tb_bucketized_hash_table.sv
